// ===== hw/rtl/pkt_crc8_pkg.sv =====
package pkt_crc8_pkg;

    localparam int COUNTER_BITS = 32;
    localparam int FRAME_LEN    = 7;
    localparam int BYTE_W       = 8;
    localparam int TOTAL_W      = 32;

    localparam logic [7:0] HEADER_MARK = 8'h55;
    localparam logic [7:0] CRC_POLY    = 8'h31;

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    // input: header, frame bytes 0..6, check byte
    localparam int IN_DATA_W  = (FRAME_LEN + 2) * BYTE_W;
    // output: status, kind, id, sequence, buttons, 5 payload bytes, two totals
    localparam int OUT_BITS   = 2 + 1 + 2 + 3 + 10 + 5 * BYTE_W + 2 * TOTAL_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_FRAMING = 2'd1,
        ST_CRC     = 2'd2
    } t_status;

    // crc register x followed by nbytes zero bytes, msb first; nbytes is a
    // constant at every call so this folds into a plain xor matrix
    function automatic logic [7:0] crc_advance(input logic [7:0] x, input int nbytes);
        logic [7:0] v;
        v = x;
        for (int i = 0; i < BYTE_W * FRAME_LEN; i++) begin
            if (i < BYTE_W * nbytes) begin
                v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/packet_crc8_check_unpack_unit.sv =====
// Checks and unpacks one 9-byte packet per request: header 0x55, seven frame
// bytes and a CRC-8 check byte (polynomial 0x31, msb first, running value
// seeded with the check byte). One packet is taken every clock cycle while
// neither side stalls; a result is presented once its request has passed the
// input register and then the result register. The seven-byte CRC chain is
// linear, so it is evaluated in one pass as an xor of per-byte terms between
// those two registers. A bad header gives status 1, a CRC mismatch status 2,
// and on either error the unpacked fields read zero. The framing and CRC
// error counters saturate and are reported after each packet. Either side
// may stall at any time; with both sides free the block runs at full rate.
module packet_crc8_check_unpack_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // header_byte, frame_byte0..frame_byte6, check_byte
    input  logic [pkt_crc8_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status, frame_kind, section_id, sequence_res, buttons, payload0..payload4,
    // framing_error_total, crc_error_total, zero fill
    output logic [pkt_crc8_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import pkt_crc8_pkg::*;

    logic                     r_in_valid;
    logic [IN_DATA_W-1:0]     r_in_data;
    logic                     r_out_valid;
    t_status                  r_status;
    logic                     r_kind;
    logic [1:0]               r_id;
    logic [2:0]               r_seq;
    logic [9:0]               r_buttons;
    logic [5*BYTE_W-1:0]      r_payload;
    logic [COUNTER_BITS-1:0]  r_fe_cnt;
    logic [COUNTER_BITS-1:0]  r_crc_cnt;

    t_status                  n_status;
    logic                     n_kind;
    logic [1:0]               n_id;
    logic [2:0]               n_seq;
    logic [9:0]               n_buttons;
    logic [5*BYTE_W-1:0]      n_payload;
    logic [COUNTER_BITS-1:0]  n_fe_cnt;
    logic [COUNTER_BITS-1:0]  n_crc_cnt;

    logic                     out_load;
    logic [7:0]               header;
    logic [7:0]               check;
    logic [7:0]               fb [FRAME_LEN];
    logic [7:0]               crc_rem;

    assign out_load      = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || out_load;

    assign header = r_in_data[BYTE_W-1:0];
    assign check  = r_in_data[(FRAME_LEN+1)*BYTE_W +: BYTE_W];

    always_comb begin
        for (int k = 0; k < FRAME_LEN; k++) begin
            fb[k] = r_in_data[(k+1)*BYTE_W +: BYTE_W];
        end
    end

    // v7 = T^7(check ^ b0) ^ T^6(b1) ^ ... ^ T^1(b6)
    always_comb begin
        crc_rem = crc_advance(check ^ fb[0], FRAME_LEN);
        for (int k = 1; k < FRAME_LEN; k++) begin
            crc_rem = crc_rem ^ crc_advance(fb[k], FRAME_LEN - k);
        end
    end

    always_comb begin
        n_fe_cnt  = r_fe_cnt;
        n_crc_cnt = r_crc_cnt;
        if (header != HEADER_MARK) begin
            n_status = ST_FRAMING;
            if (r_fe_cnt != CNT_MAX) begin
                n_fe_cnt = r_fe_cnt + 1'b1;
            end
        end else if (crc_rem != 8'd0) begin
            n_status = ST_CRC;
            if (r_crc_cnt != CNT_MAX) begin
                n_crc_cnt = r_crc_cnt + 1'b1;
            end
        end else begin
            n_status = ST_GOOD;
        end

        n_kind    = 1'b0;
        n_id      = 2'd0;
        n_seq     = 3'd0;
        n_buttons = 10'd0;
        n_payload = '0;
        if (n_status == ST_GOOD) begin
            n_kind    = fb[0][0];
            n_id      = fb[0][2:1];
            n_seq     = fb[0][5:3];
            n_buttons = {fb[1], fb[0][7:6]};
            n_payload = {fb[6], fb[5], fb[4], fb[3], fb[2]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fe_cnt    <= '0;
            r_crc_cnt   <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_fe_cnt    <= n_fe_cnt;
                r_crc_cnt   <= n_crc_cnt;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
        end
        if (out_load) begin
            r_status  <= n_status;
            r_kind    <= n_kind;
            r_id      <= n_id;
            r_seq     <= n_seq;
            r_buttons <= n_buttons;
            r_payload <= n_payload;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'({TOTAL_W'(r_crc_cnt), TOTAL_W'(r_fe_cnt), r_payload,
                                        r_buttons, r_seq, r_id, r_kind, r_status});

    a_fe_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_fe_cnt != $past(r_fe_cnt))
        |-> $past(out_load) && (r_status == ST_FRAMING))
        else $error("framing counter moved without a framing error");

    a_crc_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_crc_cnt != $past(r_crc_cnt))
        |-> $past(out_load) && (r_status == ST_CRC))
        else $error("crc counter moved without a crc error");

    a_one_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !((r_fe_cnt != $past(r_fe_cnt)) && (r_crc_cnt != $past(r_crc_cnt))))
        else $error("both error counters moved for one packet");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status != ST_GOOD)
        |-> (r_payload == '0) && (r_buttons == 10'd0) && !r_kind && (r_id == 2'd0)
            && (r_seq == 3'd0))
        else $error("unpacked fields not cleared on error");

endmodule
